### rtl/prt_pkg.sv
// shared codes and types of the protected region table
`default_nettype none
package prt_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned UsedW = 5;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_CHECK  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OVERLAP = 2'd2;
  localparam logic [1:0] ST_WRAP    = 2'd3;

  // broadcast control from the sequencer to every slot
  typedef struct packed {
    logic       load;     // evaluate the test selected by test into the mark
    logic [1:0] test;     // request code that picks the test
    logic       scan;     // marks move one slot toward slot zero
    logic       compact;  // slots at and after the first marked one take their neighbor
  } slot_ctrl_t;

endpackage
`default_nettype wire

### rtl/protected_region_table_unit.sv
// protected region table: a row of region slots and the request sequencer
//
// Requests enter on the in channel (in_valid_i / in_ready_o) as a word of
// req_type, range_start and range_size; each gives one result word on the
// out channel (out_valid_o / out_ready_i) with status and entries_used.
// One request is in work at a time: in_ready_o is high only while the
// sequencer waits for a request, from the cycle after the result is loaded.
// Add and check scan the slots toward slot zero; remove deletes regions by
// closing their gaps. Wrapping ranges, a full table on add, an add into an
// empty table, a check of an empty table and the unused request code go
// from evaluation straight to the result. The scan rate is set by the marks
// that step one slot per cycle toward slot zero; deletion closes one gap per
// cycle.
// The result sits in an output register, so the next request is accepted
// while it waits; a stalled receiver holds the finished result of that next
// request in the sequencer until the register frees up.
// Reset empties the table (count zero) and drops any pending result; the
// region storage itself is not cleared.
`default_nettype none
module protected_region_table_unit #(
  parameter int unsigned MAX_REGIONS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                req_type_i,
  input  wire logic [prt_pkg::AddrW-1:0] range_start_i,
  input  wire logic [prt_pkg::AddrW-1:0] range_size_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [1:0]                     status_o,
  output logic [prt_pkg::UsedW-1:0]      entries_used_o
);
  import prt_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_REGIONS);
  localparam logic [CntW-1:0] One    = CntW'(1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EVAL    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_COMPACT = 3'd3;
  localparam logic [2:0] S_RESP    = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [1:0]       type_q;
  logic [AddrW-1:0] start_q, size_q;
  logic [AddrW:0]   stop_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  step_q, step_d;
  logic [1:0]       status_q, status_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic [CntW-1:0]  out_count_q, out_count_d;
  logic             accept_w, append_w, any_dead_w;
  slot_ctrl_t       ctrl_w;

  logic [AddrW-1:0] base_w   [MAX_REGIONS];
  logic [AddrW-1:0] length_w [MAX_REGIONS];
  logic             mark_w   [MAX_REGIONS];
  logic [AddrW-1:0] nb_base_w   [MAX_REGIONS];
  logic [AddrW-1:0] nb_length_w [MAX_REGIONS];
  logic             nb_mark_w   [MAX_REGIONS];
  logic [MAX_REGIONS:0] seen_w;
  logic [CntW+UsedW-1:0] used_x;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept_w   = in_valid_i & in_ready_o;
  assign seen_w[0]  = 1'b0;
  assign any_dead_w = seen_w[MAX_REGIONS];

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_slot
    if (i == MAX_REGIONS - 1) begin : g_tail
      assign nb_base_w[i]   = '0;
      assign nb_length_w[i] = '0;
      assign nb_mark_w[i]   = 1'b0;
    end else begin : g_body
      assign nb_base_w[i]   = base_w[i+1];
      assign nb_length_w[i] = length_w[i+1];
      assign nb_mark_w[i]   = mark_w[i+1];
    end

    prt_slot u_slot (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_w),
      .valid_i     (count_q > CntW'(i)),
      .write_i     (append_w && (count_q == CntW'(i))),
      .start_i     (start_q),
      .size_i      (size_q),
      .stop_i      (stop_q),
      .nb_base_i   (nb_base_w[i]),
      .nb_length_i (nb_length_w[i]),
      .nb_mark_i   (nb_mark_w[i]),
      .seen_i      (seen_w[i]),
      .base_o      (base_w[i]),
      .length_o    (length_w[i]),
      .mark_o      (mark_w[i]),
      .seen_o      (seen_w[i+1])
    );
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    step_d       = step_q;
    status_d     = status_q;
    append_w     = 1'b0;
    ctrl_w.load    = 1'b0;
    ctrl_w.test    = type_q;
    ctrl_w.scan    = 1'b0;
    ctrl_w.compact = 1'b0;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept_w) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        status_d = ST_OK;
        step_d   = '0;
        if (stop_q[AddrW]) begin
          status_d = ST_WRAP;
          state_d  = S_RESP;
        end else begin
          case (type_q)
            REQ_ADD: begin
              if (count_q >= MaxCnt) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else if (count_q == '0) begin
                append_w = 1'b1;
                count_d  = count_q + One;
                state_d  = S_RESP;
              end else begin
                ctrl_w.load = 1'b1;
                state_d     = S_SCAN;
              end
            end
            REQ_REMOVE: begin
              ctrl_w.load = 1'b1;
              state_d     = S_COMPACT;
            end
            REQ_CHECK: begin
              ctrl_w.load = 1'b1;
              state_d     = (count_q == '0) ? S_RESP : S_SCAN;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        ctrl_w.scan = 1'b1;
        if (mark_w[0]) begin
          // hit at the head slot
          status_d = (type_q == REQ_CHECK) ? ST_OVERLAP : ST_OK;
          state_d  = S_RESP;
        end else if (step_q + One >= count_q) begin
          if (type_q == REQ_ADD) begin
            append_w = 1'b1;
            count_d  = count_q + One;
          end
          state_d = S_RESP;
        end else begin
          step_d = step_q + One;
        end
      end
      S_COMPACT: begin
        // each cycle closes the first gap
        if (any_dead_w) begin
          ctrl_w.compact = 1'b1;
          count_d        = count_q - One;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      type_q  <= req_type_i;
      start_q <= range_start_i;
      size_q  <= range_size_i;
      stop_q  <= {1'b0, range_start_i} + {1'b0, range_size_i};
    end
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign used_x         = {{UsedW{1'b0}}, out_count_q};
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign entries_used_o = used_x[UsedW-1:0];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("region count above table size");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    append_w |-> (count_q < MaxCnt))
    else $error("append into a full table");

  a_compact_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMPACT) |=> (count_q <= $past(count_q)))
    else $error("count grew while closing gaps");

  a_compact_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMPACT && !any_dead_w) |=> (state_q == S_RESP))
    else $error("gap closing did not finish");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w |=> (state_q == S_EVAL))
    else $error("accepted word not evaluated");
`endif

endmodule
`default_nettype wire

### rtl/prt_slot.sv
// one table slot: region storage, range tests and a mark bit shared with its neighbors
`default_nettype none
module prt_slot (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire prt_pkg::slot_ctrl_t      ctrl_i,
  input  wire logic                     valid_i,
  input  wire logic                     write_i,
  input  wire logic [prt_pkg::AddrW-1:0] start_i,
  input  wire logic [prt_pkg::AddrW-1:0] size_i,
  input  wire logic [prt_pkg::AddrW:0]   stop_i,
  input  wire logic [prt_pkg::AddrW-1:0] nb_base_i,
  input  wire logic [prt_pkg::AddrW-1:0] nb_length_i,
  input  wire logic                     nb_mark_i,
  input  wire logic                     seen_i,
  output logic [prt_pkg::AddrW-1:0]      base_o,
  output logic [prt_pkg::AddrW-1:0]      length_o,
  output logic                          mark_o,
  output logic                          seen_o
);
  import prt_pkg::*;

  logic [AddrW-1:0] base_q, base_d;
  logic [AddrW-1:0] length_q, length_d;
  logic             mark_q, mark_d;
  logic [AddrW:0]   end_w;
  logic [AddrW:0]   start_x;
  logic [AddrW:0]   base_x;
  logic             contain_w, inside_w, overlap_w, test_w, shift_w;

  assign end_w   = {1'b0, base_q} + {1'b0, length_q};
  assign start_x = {1'b0, start_i};
  assign base_x  = {1'b0, base_q};

  assign contain_w = (start_i >= base_q) && (stop_i <= end_w);
  assign inside_w  = (start_i <= base_q) && (stop_i >= end_w);
  assign overlap_w = (start_x < end_w) && (stop_i > base_x);

  // a slot moves once any slot up to and including it is marked
  assign shift_w = seen_i | mark_q;
  assign seen_o  = shift_w;

  always_comb begin
    case (ctrl_i.test)
      REQ_ADD:    test_w = contain_w;
      REQ_REMOVE: test_w = inside_w;
      REQ_CHECK:  test_w = overlap_w;
      default:    test_w = 1'b0;
    endcase
  end

  always_comb begin
    mark_d = mark_q;
    if (ctrl_i.load) begin
      mark_d = valid_i & test_w;
    end else if (ctrl_i.scan || (ctrl_i.compact && shift_w)) begin
      mark_d = nb_mark_i;
    end
  end

  always_comb begin
    base_d   = base_q;
    length_d = length_q;
    if (write_i) begin
      base_d   = start_i;
      length_d = size_i;
    end else if (ctrl_i.compact && shift_w) begin
      base_d   = nb_base_i;
      length_d = nb_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else begin
      mark_q <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    length_q <= length_d;
  end

  assign base_o   = base_q;
  assign length_o = length_q;
  assign mark_o   = mark_q;

endmodule
`default_nettype wire

### verif/protected_region_table_unit_tb.sv
// testbench for the protected region table: queued requests, scoreboard against a behavioral table
`timescale 1ns / 1ps
module protected_region_table_unit_tb;
  import prt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 950;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] base_addr;
    logic [AddrW-1:0] len;
  } region_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [UsedW-1:0] used;
  } region_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       req_type_i = REQ_ADD;
  logic [AddrW-1:0] range_start_i = '0;
  logic [AddrW-1:0] range_size_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [1:0]       status_o;
  logic [UsedW-1:0] entries_used_o;

  protected_region_table_unit #(
    .MAX_REGIONS(TABLE_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .range_start_i (range_start_i),
    .range_size_i  (range_size_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entries_used_o(entries_used_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // behavioral copy of the table
  logic [AddrW-1:0] model_base[TABLE_DEPTH];
  logic [AddrW-1:0] model_len[TABLE_DEPTH];
  int unsigned      model_count = 0;

  region_req_t    request_q[$];
  region_result_t expected_status_q[$];

  int unsigned total_items = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fail_cnt = 0;
  int unsigned status_cnt[4] = '{0, 0, 0, 0};
  int unsigned peak_used = 0;

  function automatic region_result_t apply_request(region_req_t rq);
    region_result_t res;
    logic [AddrW:0] stop;
    logic [AddrW:0] ent_end;
    int unsigned    k;
    int unsigned    wr;
    bit             hit;
    res.status = ST_OK;
    stop = {1'b0, rq.base_addr} + {1'b0, rq.len};
    hit = 1'b0;
    wr = 0;
    if (stop[AddrW]) begin
      res.status = ST_WRAP;
    end else begin
      case (rq.kind)
        REQ_ADD: begin
          if (model_count >= TABLE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            for (k = 0; k < model_count; k++) begin
              ent_end = {1'b0, model_base[k]} + {1'b0, model_len[k]};
              if (rq.base_addr >= model_base[k] && stop <= ent_end) hit = 1'b1;
            end
            if (!hit) begin
              model_base[model_count] = rq.base_addr;
              model_len[model_count] = rq.len;
              model_count++;
            end
          end
        end
        REQ_REMOVE: begin
          // keep survivors in order, closing the gaps
          for (k = 0; k < model_count; k++) begin
            ent_end = {1'b0, model_base[k]} + {1'b0, model_len[k]};
            if (!(rq.base_addr <= model_base[k] && stop >= ent_end)) begin
              model_base[wr] = model_base[k];
              model_len[wr] = model_len[k];
              wr++;
            end
          end
          model_count = wr;
        end
        REQ_CHECK: begin
          for (k = 0; k < model_count; k++) begin
            ent_end = {1'b0, model_base[k]} + {1'b0, model_len[k]};
            if ({1'b0, rq.base_addr} < ent_end && stop > {1'b0, model_base[k]}) hit = 1'b1;
          end
          if (hit) res.status = ST_OVERLAP;
        end
        default: ;
      endcase
    end
    res.used = model_count[UsedW-1:0];
    return res;
  endfunction

  function automatic void queue_req(logic [1:0] k, logic [AddrW-1:0] s, logic [AddrW-1:0] z);
    request_q.push_back('{k, s, z});
  endfunction

  // sender: bursts of words separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    region_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_status_q.push_back(apply_request('{req_type_i, range_start_i, range_size_i}));
        items_sent <= items_sent + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          nxt = request_q.pop_front();
          req_type_i <= nxt.kind;
          range_start_i <= nxt.base_addr;
          range_size_i <= nxt.len;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left <= 0;
              3, 4, 5, 6: gap_left <= $urandom_range(1, 3);
              default: gap_left <= $urandom_range(4, 14);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 200;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      next_hold_at <= 200;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen == next_hold_at) begin
      hold_left <= 150;
      next_hold_at <= next_hold_at + 400;
    end
  end

  // receiver and scoreboard
  logic [31:0] rx_cycle = '0;
  logic [1:0]  rx_mode = '0;

  always @(posedge clk_i or negedge rst_ni) begin
    region_result_t exp_res;
    logic           go;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_cycle <= '0;
      rx_mode <= '0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        status_cnt[status_o] <= status_cnt[status_o] + 1;
        if (entries_used_o > peak_used) peak_used <= entries_used_o;
        if (expected_status_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("unexpected word: status %0d entries %0d", status_o, entries_used_o);
          fail_cnt <= fail_cnt + 1;
        end else begin
          exp_res = expected_status_q.pop_front();
          if (exp_res.status !== status_o || exp_res.used !== entries_used_o) begin
            if (fail_cnt < 10)
              $display("mismatch on word %0d: status exp %0d got %0d, entries exp %0d got %0d",
                       results_seen, exp_res.status, status_o, exp_res.used, entries_used_o);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
      case (rx_mode)
        2'd0: go = 1'b1;
        2'd1: go = ($urandom_range(0, 1) == 0);
        2'd2: go = ($urandom_range(0, 9) != 0);
        default: go = (rx_cycle % 5 != 0);
      endcase
      out_ready_i <= go && (hold_left == 0);
    end
  end

  initial begin
    #3_000_000;
    $display("timeout waiting for the table to drain");
    $display("Verification failed");
    $finish;
  end

  initial begin
    region_req_t      rq;
    region_req_t      ref_rng;
    region_req_t      recent_q[$];
    logic [AddrW-1:0] b;
    logic [AddrW-1:0] l;
    int unsigned      counted;
    int unsigned      mode;
    int unsigned      pick;
    int unsigned      i;
    counted = 0;

    // directed: empty table, address extremes, wrap edge, unused code, fill, full, compaction
    queue_req(REQ_CHECK, 32'h0, 32'h0);
    queue_req(REQ_ADD, 32'hFFFF_FFFF, 32'h0);
    queue_req(REQ_ADD, 32'hFFFF_FFFF, 32'h1);
    queue_req(REQ_REMOVE, 32'h1, 32'hFFFF_FFFF);
    queue_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(REQ_UNUSED, 32'h1234, 32'h10);
    for (i = 0; i < 15; i++) queue_req(REQ_ADD, i * 32'h1000, 32'h100);
    queue_req(REQ_ADD, 32'h10, 32'h10);          // contained, but table is full
    queue_req(REQ_CHECK, 32'h1080, 32'h0);       // zero size strictly inside an entry
    queue_req(REQ_REMOVE, 32'h1000, 32'h3000);   // drops a run from the middle
    queue_req(REQ_CHECK, 32'h1000, 32'h1000);
    queue_req(REQ_ADD, 32'h0, 32'hFFFF_FFFF);
    queue_req(REQ_CHECK, 32'h8000_0000, 32'h0);
    queue_req(REQ_REMOVE, 32'h0, 32'hFFFF_FFFF);  // clears everything

    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) rq.kind = REQ_ADD;
      else if (pick < 64) rq.kind = REQ_REMOVE;
      else if (pick < 95) rq.kind = REQ_CHECK;
      else rq.kind = REQ_UNUSED;
      if (recent_q.size() != 0) ref_rng = recent_q[$urandom_range(0, recent_q.size() - 1)];
      else ref_rng = '{REQ_ADD, 32'h100, 32'h80};
      b = ref_rng.base_addr;
      l = ref_rng.len;
      mode = $urandom_range(0, 99);
      if (mode < 8) begin
        rq.base_addr = $urandom;
        rq.len = $urandom;
      end else if (mode < 13) begin
        rq.base_addr = 32'hFFFF_FFFF - $urandom_range(0, 32'h1000);
        rq.len = $urandom_range(0, 32'h2000);
      end else if (mode < 18 && rq.kind != REQ_ADD) begin
        rq.base_addr = $urandom_range(0, 32'hFF);
        // sometimes the sum lands exactly on 2^32
        if ($urandom_range(0, 3) == 0) rq.len = 32'h0 - rq.base_addr;
        else rq.len = 32'hFFFF_FFFF - rq.base_addr - $urandom_range(0, 32'h100);
      end else begin
        case (rq.kind)
          REQ_ADD: begin
            if ($urandom_range(0, 2) == 0) begin
              rq.base_addr = b + $urandom_range(0, l);
              rq.len = $urandom_range(0, b + l - rq.base_addr);
            end else begin
              rq.base_addr = $urandom_range(0, 32'hFFFF);
              rq.len = $urandom_range(0, 32'h1FFF);
            end
          end
          REQ_REMOVE: begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
              rq.base_addr = b - $urandom_range(0, (b < 256) ? b : 256);
              rq.len = (b - rq.base_addr) + l + $urandom_range(0, 256);
            end else if (pick < 9) begin
              rq.base_addr = $urandom_range(0, 32'hFFFF);
              rq.len = $urandom_range(0, 32'h1FFF);
            end else begin
              rq.base_addr = $urandom_range(0, 32'h4000);
              rq.len = $urandom_range(32'h4000, 32'h20000);
            end
          end
          default: begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
              rq.base_addr = ((b < 32'h40) ? 32'h0 : b - 32'h40) + $urandom_range(0, l + 32'h80);
              rq.len = $urandom_range(0, 32'h100);
            end else if (pick < 6) begin
              // touching the end of an entry
              rq.base_addr = b + l;
              rq.len = $urandom_range(0, 32'h100);
            end else if (pick < 7) begin
              // touching the start of an entry
              rq.len = $urandom_range(0, (b < 256) ? b : 256);
              rq.base_addr = b - rq.len;
            end else begin
              rq.base_addr = $urandom_range(0, 32'hFFFF);
              rq.len = $urandom_range(0, 32'h1FFF);
            end
          end
        endcase
        if (rq.kind == REQ_ADD) begin
          recent_q.push_back(rq);
          if (recent_q.size() > 24) void'(recent_q.pop_front());
        end
      end
      request_q.push_back(rq);
      if (rq.kind != REQ_UNUSED) counted++;
    end
    total_items = request_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_sent != total_items) @(posedge clk_i);
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (expected_status_q.size() != 0) fail_cnt = fail_cnt + 1;
    $display("%0d requests checked: %0d ok, %0d table full, %0d overlap, %0d wrap",
             results_seen, status_cnt[ST_OK], status_cnt[ST_FULL], status_cnt[ST_OVERLAP],
             status_cnt[ST_WRAP]);
    $display("table occupancy peaked at %0d of %0d entries, %0d mismatches",
             peak_used, TABLE_DEPTH, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
